[rtl/core/nfrs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfrs_pkg: shared types and constants of the nearest free resource search
// Table geometry, operation and status codes, and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package nfrs_pkg;

	localparam int ENTRIES    = 256;
	localparam int COORD_BITS = 16;
	localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_BITS   = $clog2(ENTRIES + 1);
	localparam int SQ_BITS    = 2 * COORD_BITS;
	localparam int DIST_BITS  = SQ_BITS + 1;

	localparam int FUNC_BITS   = 3;
	localparam int STATUS_BITS = 2;
	localparam int KIND_BITS   = 2;
	localparam int PORT_COORD  = 16;

	typedef enum logic [FUNC_BITS-1:0] {
		FN_LOAD      = 3'd0,
		FN_CLEAR     = 3'd1,
		FN_FIND      = 3'd2,
		FN_RESERVE   = 3'd3,
		FN_UNRESERVE = 3'd4,
		FN_REMOVE    = 3'd5
	} func_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK   = 2'd0,
		ST_NONE = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [IDX_BITS-1:0]   idx_t;

	typedef struct packed {
		coord_t               x;
		coord_t               y;
		logic [KIND_BITS-1:0] kind;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic capture; // latch the incoming item, arm a new search
		logic step;    // issue the next table slot into the scan pipeline
		logic commit;  // apply the table update and load the result register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_scan; // the held item walks the table
		logic last;      // the slot being issued is the final one
		logic busy;      // scan pipeline still holds slots in flight
		logic out_free;  // result register can take a new result
	} dp_sts_t;

endpackage
`default_nettype wire

[rtl/core/nfrs_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfrs_dp: datapath of the nearest free resource search
// Entry memory, valid and reserved flags, fill count, the four-stage
// distance scan pipeline, the best-so-far tracker and the result register.
// ----------------------------------------------------------------------------
module nfrs_dp
	import nfrs_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire dp_cmd_t                cmd,
	output dp_sts_t                     sts,
	input  wire logic [FUNC_BITS-1:0]   func,
	input  wire logic [PORT_COORD-1:0]  in_x,
	input  wire logic [PORT_COORD-1:0]  in_y,
	input  wire logic [KIND_BITS-1:0]   kind,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [STATUS_BITS-1:0]      status,
	output logic [PORT_COORD-1:0]       res_x,
	output logic [PORT_COORD-1:0]       res_y
);

	entry_t               mem [ENTRIES];
	logic [ENTRIES-1:0]   valid_q;
	logic [ENTRIES-1:0]   rsv_q;
	logic [CNT_BITS-1:0]  fill_q;
	logic                 full;

	logic [FUNC_BITS-1:0] func_q;
	coord_t               qx_q;
	coord_t               qy_q;
	logic [KIND_BITS-1:0] kind_q;

	idx_t                 idx_q;

	// stage 1: slot read
	entry_t               ent_s1;
	logic                 vld_s1;
	logic                 rsv_s1;
	idx_t                 idx_s1;
	logic                 live_s1;
	// stage 2: differences and filters
	coord_t               dx_s2;
	coord_t               dy_s2;
	coord_t               x_s2;
	coord_t               y_s2;
	logic                 cand_s2;
	logic                 match_s2;
	idx_t                 idx_s2;
	logic                 live_s2;
	// stage 3: squares
	logic [SQ_BITS-1:0]   sx_s3;
	logic [SQ_BITS-1:0]   sy_s3;
	coord_t               x_s3;
	coord_t               y_s3;
	logic                 cand_s3;
	logic                 match_s3;
	idx_t                 idx_s3;
	logic                 live_s3;

	logic [DIST_BITS-1:0] sum_sq;
	logic [DIST_BITS-1:0] best_dist_q;
	idx_t                 best_idx_q;
	coord_t               best_x_q;
	coord_t               best_y_q;
	logic                 found_q;

	logic                 out_valid_q;
	logic [STATUS_BITS-1:0] status_q;
	logic [PORT_COORD-1:0] res_x_q;
	logic [PORT_COORD-1:0] res_y_q;

	logic [STATUS_BITS-1:0] nxt_status;
	logic [PORT_COORD-1:0] nxt_x;
	logic [PORT_COORD-1:0] nxt_y;
	idx_t                 fill_idx;

	assign full     = (fill_q == CNT_BITS'(ENTRIES));
	assign fill_idx = fill_q[IDX_BITS-1:0];
	assign sum_sq   = {1'b0, sx_s3} + {1'b0, sy_s3};

	assign sts.need_scan = (func_q == FN_FIND) || (func_q == FN_RESERVE)
		|| (func_q == FN_UNRESERVE) || (func_q == FN_REMOVE);
	assign sts.last      = (idx_q == IDX_BITS'(ENTRIES - 1));
	assign sts.busy      = live_s1 | live_s2 | live_s3;
	assign sts.out_free  = !out_valid_q || out_ready;

	// held item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			qx_q   <= COORD_BITS'(in_x);
			qy_q   <= COORD_BITS'(in_y);
			kind_q <= kind;
		end
	end

	// entry memory: one write port for loads, one registered read port for the scan
	always_ff @(posedge clk) begin
		if (cmd.commit && func_q == FN_LOAD && !full) begin
			mem[fill_idx] <= '{x: qx_q, y: qy_q, kind: kind_q};
		end
		ent_s1 <= mem[idx_q];
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		vld_s1   <= valid_q[idx_q];
		rsv_s1   <= rsv_q[idx_q];
		idx_s1   <= idx_q;

		dx_s2    <= (ent_s1.x >= qx_q) ? ent_s1.x - qx_q : qx_q - ent_s1.x;
		dy_s2    <= (ent_s1.y >= qy_q) ? ent_s1.y - qy_q : qy_q - ent_s1.y;
		x_s2     <= ent_s1.x;
		y_s2     <= ent_s1.y;
		cand_s2  <= vld_s1 && (ent_s1.kind == kind_q)
			&& !(func_q == FN_RESERVE && rsv_s1);
		match_s2 <= vld_s1 && (ent_s1.x == qx_q) && (ent_s1.y == qy_q);
		idx_s2   <= idx_s1;

		sx_s3    <= dx_s2 * dx_s2;
		sy_s3    <= dy_s2 * dy_s2;
		x_s3     <= x_s2;
		y_s3     <= y_s2;
		cand_s3  <= cand_s2;
		match_s3 <= match_s2;
		idx_s3   <= idx_s2;
	end

	// scan address and slot tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			live_s1 <= 1'b0;
			live_s2 <= 1'b0;
			live_s3 <= 1'b0;
		end else begin
			if (cmd.capture) begin
				idx_q <= '0;
			end else if (cmd.step) begin
				idx_q <= idx_q + 1'b1;
			end
			live_s1 <= cmd.step;
			live_s2 <= live_s1;
			live_s3 <= live_s2;
		end
	end

	// best-so-far tracker; strict compare keeps the lowest slot on a tie
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.capture) begin
			found_q <= 1'b0;
		end else if (live_s3) begin
			case (func_q)
				FN_FIND, FN_RESERVE: begin
					if (cand_s3 && (!found_q || sum_sq < best_dist_q)) begin
						found_q <= 1'b1;
					end
				end
				FN_UNRESERVE, FN_REMOVE: begin
					if (match_s3) begin
						found_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (live_s3) begin
			if ((func_q == FN_FIND || func_q == FN_RESERVE) && cand_s3
				&& (!found_q || sum_sq < best_dist_q)) begin
				best_dist_q <= sum_sq;
				best_idx_q  <= idx_s3;
				best_x_q    <= x_s3;
				best_y_q    <= y_s3;
			end else if (func_q == FN_REMOVE && match_s3 && !found_q) begin
				best_idx_q  <= idx_s3;
			end
		end
	end

	// valid and reserved flags, fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rsv_q   <= '0;
			fill_q  <= '0;
		end else begin
			if (live_s3 && match_s3 && func_q == FN_UNRESERVE) begin
				rsv_q[idx_s3] <= 1'b0;
			end
			if (cmd.commit) begin
				case (func_q)
					FN_LOAD: begin
						if (!full) begin
							valid_q[fill_idx] <= 1'b1;
							rsv_q[fill_idx]   <= 1'b0;
							fill_q            <= fill_q + 1'b1;
						end
					end
					FN_CLEAR: begin
						valid_q <= '0;
						rsv_q   <= '0;
						fill_q  <= '0;
					end
					FN_RESERVE: begin
						if (found_q) begin
							rsv_q[best_idx_q] <= 1'b1;
						end
					end
					FN_REMOVE: begin
						if (found_q) begin
							valid_q[best_idx_q] <= 1'b0;
							rsv_q[best_idx_q]   <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// result of the held item
	always_comb begin
		nxt_x = '0;
		nxt_y = '0;
		case (func_q)
			FN_LOAD: begin
				nxt_status = full ? ST_FULL : ST_OK;
			end
			FN_CLEAR: begin
				nxt_status = ST_OK;
			end
			FN_FIND, FN_RESERVE: begin
				nxt_status = found_q ? ST_OK : ST_NONE;
				if (found_q) begin
					nxt_x = PORT_COORD'(best_x_q);
					nxt_y = PORT_COORD'(best_y_q);
				end
			end
			FN_UNRESERVE, FN_REMOVE: begin
				nxt_status = found_q ? ST_OK : ST_NONE;
			end
			default: begin
				nxt_status = ST_NONE;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= nxt_status;
			res_x_q  <= nxt_x;
			res_y_q  <= nxt_y;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign res_x     = res_x_q;
	assign res_y     = res_y_q;

endmodule
`default_nettype wire

[rtl/core/nfrs_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfrs_ctrl: controller of the nearest free resource search
// Sequences one item at a time: capture, decode, a table scan and pipeline drain
// where the operation needs one, and commit of the table update together with the result.
// ----------------------------------------------------------------------------
module nfrs_ctrl
	import nfrs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output dp_cmd_t      cmd,
	input  wire dp_sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t state_q;

	assign in_ready    = (state_q == S_IDLE);
	assign cmd.capture = (state_q == S_IDLE) && in_valid;
	assign cmd.step    = (state_q == S_SCAN);
	assign cmd.commit  = (state_q == S_FINISH) && sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					state_q <= sts.need_scan ? S_SCAN : S_FINISH;
				end
				S_SCAN: begin
					if (sts.last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!sts.busy) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/core/nearest_free_resource_search.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_free_resource_search: nearest free resource search, top level
// Keeps a table of resource points and answers load, clear, find nearest,
// reserve nearest, unreserve and remove operations, one result per item.
//
//   channel | signals                       | direction | one item
//   --------+-------------------------------+-----------+-------------------
//   in      | in_valid in_ready             | into      | func in_x in_y kind
//   out     | out_valid out_ready           | out of    | status res_x res_y
//
// Load, clear and unused codes go from decode straight to commit of the result;
//   the next item is taken once the result is committed.
// Find, reserve, unreserve and remove walk every table slot through a
//   four-stage scan pipeline (read, difference, square, compare), issuing
//   slots one at a time through the single memory read port; the pipeline
//   drains before the result is committed and the next item can be taken.
// One item is in work at a time; in_ready is high only while idle.
// The result register holds a finished item while the next one is taken;
//   a stalled out_ready stops the block only when a second result is ready.
// Reset clears flags and fill count at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module nearest_free_resource_search
	import nfrs_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [FUNC_BITS-1:0]   func,
	input  wire logic [PORT_COORD-1:0]  in_x,
	input  wire logic [PORT_COORD-1:0]  in_y,
	input  wire logic [KIND_BITS-1:0]   kind,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [STATUS_BITS-1:0]      status,
	output logic [PORT_COORD-1:0]       res_x,
	output logic [PORT_COORD-1:0]       res_y
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencing: capture, scan, drain, commit
	nfrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// table storage, distance pipeline and result register
	nfrs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.func      (func),
		.in_x      (in_x),
		.in_y      (in_y),
		.kind      (kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.res_x     (res_x),
		.res_y     (res_y)
	);

endmodule
`default_nettype wire
